// File: rtl/core/lir_pkg.sv
// Shared types and constants of the linear interpolation resampler.
// Used by the channel interfaces, the multiply unit and the top level.
package lir_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int CHAN_BITS    = 2;
    localparam int PHASE_BITS   = 19;
    localparam int OUTCNT_BITS  = 32;
    localparam int POS_BITS     = 48;
    localparam int FRAME_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam int MAX_RESULTS = 20;
    localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);

    localparam int MAX_CHANNELS_DEF = 2;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int COUNT_BITS_DEF   = 32;

    localparam logic [CHAN_BITS-1:0]   CHAN_RESET   = 2'd2;
    localparam logic [CHAN_BITS-1:0]   CHAN_STEREO  = 2'd2;
    localparam logic [PHASE_BITS-1:0]  PHASE_RESET  = 19'd65536;
    localparam logic [OUTCNT_BITS-1:0] OUTCNT_RESET = 32'd0;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTPUT_COUNT  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CALC_L,
        ST_CALC_R,
        ST_FORM
    } lir_state_t;

endpackage

// File: rtl/core/lir_if.sv
// Valid/ready channel interfaces for input frames and resampled frames.
// Depends on lir_pkg for the sample width.
interface lir_in_if import lir_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
    logic                          final_frame;

    modport source (output valid, output in_left, output in_right, output final_frame,
                    input ready);
    modport sink   (input valid, input in_left, input in_right, input final_frame,
                    output ready);
endinterface

interface lir_out_if import lir_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          run_end;
    logic                          stream_end;

    modport source (output valid, output out_left, output out_right, output run_end,
                    output stream_end, input ready);
    modport sink   (input valid, input out_left, input out_right, input run_end,
                     input stream_end, output ready);
endinterface

// File: rtl/core/lir_mac.sv
// Shared interpolation unit: one registered multiply of fraction by difference,
// then rounding toward zero and clamping. Depends on lir_pkg.
module lir_mac import lir_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic        [FRAC_BITS-1:0]   frac,
    input  logic signed [SAMPLE_BITS-1:0] base,
    input  logic signed [SAMPLE_BITS-1:0] target,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = FRAC_BITS + DIFF_BITS + 1;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int Q_BITS    = SUM_BITS - FRAC_BITS;

    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [SAMPLE_BITS-1:0] base_reg;
    logic signed [DIFF_BITS-1:0]   diff;
    logic signed [SUM_BITS-1:0]    sum;
    logic signed [Q_BITS-1:0]      quot;
    logic signed [Q_BITS-1:0]      quot_adj;

    localparam logic signed [Q_BITS-1:0] Q_MAX = Q_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [Q_BITS-1:0] Q_MIN = -Q_BITS'(2 ** (SAMPLE_BITS - 1));

    assign diff = DIFF_BITS'(target) - DIFF_BITS'(base);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_BITS'($signed({1'b0, frac}) * diff);
            base_reg <= base;
        end
    end

    always_comb
    begin
        sum  = (SUM_BITS'(base_reg) <<< FRAC_BITS) + SUM_BITS'(prod_reg);
        quot = Q_BITS'(sum >>> FRAC_BITS);
        if (sum[SUM_BITS-1] && (|sum[FRAC_BITS-1:0]))
        begin
            quot_adj = quot + Q_BITS'(1);
        end
        else
        begin
            quot_adj = quot;
        end
        if (quot_adj > Q_MAX)
        begin
            sample = SAMPLE_BITS'(Q_MAX);
        end
        else if (quot_adj < Q_MIN)
        begin
            sample = SAMPLE_BITS'(Q_MIN);
        end
        else
        begin
            sample = SAMPLE_BITS'(quot_adj);
        end
    end

endmodule

// File: rtl/core/linear_interp_resampler.sv
// Linear interpolation resampler for mono or stereo 16-bit frames. Each result
// passes through the states EVAL, CALC_L, CALC_R and FORM, and EVAL waits while
// a result is pending and the output side stalls. While an input frame yields its
// results the block takes no new frame. The single multiply unit serves the left
// and then the right channel of every result. A finished result waits in an output
// register while the next one is computed. Depends on lir_pkg, lir_if and lir_mac.
module linear_interp_resampler import lir_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    lir_in_if.sink                   in_ch,
    lir_out_if.source                out_ch
);

    lir_state_t state_reg;
    lir_state_t state_next;

    logic [CHAN_BITS-1:0]   chan_count_reg;
    logic [PHASE_BITS-1:0]  phase_step_reg;
    logic [OUTCNT_BITS-1:0] output_count_reg;

    logic signed [SAMPLE_BITS-1:0] cur_l_reg;
    logic signed [SAMPLE_BITS-1:0] cur_r_reg;
    logic                          fin_reg;
    logic signed [SAMPLE_BITS-1:0] prev_l_reg;
    logic signed [SAMPLE_BITS-1:0] prev_r_reg;
    logic                          have_prev_reg;
    logic [FRAME_BITS-1:0]         frame_reg;
    logic [POS_BITS-1:0]           pos_reg;
    logic [COUNT_BITS-1:0]         emitted_reg;
    logic [RES_CNT_BITS-1:0]       cnt_reg;
    logic                          interp_reg;

    logic                          pend_reg;
    logic signed [SAMPLE_BITS-1:0] pend_l_reg;
    logic signed [SAMPLE_BITS-1:0] pend_r_reg;
    logic                          pend_se_reg;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_l_reg;
    logic signed [SAMPLE_BITS-1:0] out_r_reg;
    logic                          out_run_reg;
    logic                          out_se_reg;

    logic [POS_BITS-1:0]           pos_shift;
    logic [FRAME_BITS-1:0]         pint;
    logic [COUNT_BITS-1:0]         limit;
    logic [COUNT_BITS-1:0]         emitted_inc;
    logic                          stereo;
    logic                          interp_now;
    logic                          emit_more;
    logic                          can_load;
    logic                          accept;
    logic                          load_out;
    logic                          finish;
    logic                          mac_load;
    logic signed [SAMPLE_BITS-1:0] mac_base;
    logic signed [SAMPLE_BITS-1:0] mac_target;
    logic signed [SAMPLE_BITS-1:0] mac_sample;

    assign pos_shift   = pos_reg >> FRAC_BITS;
    assign pint        = pos_shift[FRAME_BITS-1:0];
    assign limit       = COUNT_BITS'(output_count_reg);
    assign emitted_inc = emitted_reg + COUNT_BITS'(1);
    assign stereo      = (MAX_CHANNELS >= 2) && (chan_count_reg >= CHAN_STEREO);
    assign interp_now  = have_prev_reg && (pint < frame_reg);
    assign emit_more   = (cnt_reg < RES_CNT_BITS'(MAX_RESULTS)) && (emitted_reg != limit)
                         && (interp_now || fin_reg);
    assign can_load    = !out_valid_reg || out_ch.ready;

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_left   = out_l_reg;
    assign out_ch.out_right  = out_r_reg;
    assign out_ch.run_end    = out_run_reg;
    assign out_ch.stream_end = out_se_reg;

    assign mac_base   = (state_reg == ST_CALC_L) ? prev_l_reg : prev_r_reg;
    assign mac_target = (state_reg == ST_CALC_L) ? cur_l_reg : cur_r_reg;

    lir_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .load   (mac_load),
        .frac   (pos_reg[FRAC_BITS-1:0]),
        .base   (mac_base),
        .target (mac_target),
        .sample (mac_sample)
    );

    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        load_out   = 1'b0;
        finish     = 1'b0;
        mac_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    accept     = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!pend_reg || can_load)
                begin
                    load_out = pend_reg;
                    if (emit_more)
                    begin
                        state_next = ST_CALC_L;
                    end
                    else
                    begin
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CALC_L:
            begin
                mac_load   = 1'b1;
                state_next = ST_CALC_R;
            end
            ST_CALC_R:
            begin
                mac_load   = 1'b1;
                state_next = ST_FORM;
            end
            ST_FORM:
            begin
                state_next = ST_EVAL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            chan_count_reg   <= CHAN_RESET;
            phase_step_reg   <= PHASE_RESET;
            output_count_reg <= OUTCNT_RESET;
            prev_l_reg       <= '0;
            prev_r_reg       <= '0;
            have_prev_reg    <= 1'b0;
            frame_reg        <= '0;
            pos_reg          <= '0;
            emitted_reg      <= '0;
            cnt_reg          <= '0;
            interp_reg       <= 1'b0;
            pend_reg         <= 1'b0;
            pend_se_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHANNEL_COUNT: chan_count_reg   <= cfg_data[CHAN_BITS-1:0];
                    CFG_PHASE_STEP:    phase_step_reg   <= cfg_data[PHASE_BITS-1:0];
                    CFG_OUTPUT_COUNT:  output_count_reg <= cfg_data[OUTCNT_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (accept)
            begin
                cnt_reg <= '0;
            end

            if (state_reg == ST_EVAL)
            begin
                interp_reg <= interp_now;
            end

            if (load_out)
            begin
                pend_reg <= 1'b0;
            end
            else if (state_reg == ST_FORM)
            begin
                pend_reg    <= 1'b1;
                pend_se_reg <= (emitted_inc == limit);
                emitted_reg <= emitted_inc;
                pos_reg     <= pos_reg + POS_BITS'(phase_step_reg);
                cnt_reg     <= cnt_reg + RES_CNT_BITS'(1);
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (finish)
            begin
                prev_l_reg <= cur_l_reg;
                prev_r_reg <= cur_r_reg;
                if (fin_reg)
                begin
                    have_prev_reg <= 1'b0;
                    frame_reg     <= '0;
                    pos_reg       <= '0;
                    emitted_reg   <= '0;
                end
                else
                begin
                    have_prev_reg <= 1'b1;
                    frame_reg     <= frame_reg + FRAME_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_l_reg <= in_ch.in_left;
            cur_r_reg <= in_ch.in_right;
            fin_reg   <= in_ch.final_frame;
        end
        if (state_reg == ST_CALC_R)
        begin
            pend_l_reg <= interp_reg ? mac_sample : cur_l_reg;
        end
        if (state_reg == ST_FORM)
        begin
            if (!stereo)
            begin
                pend_r_reg <= '0;
            end
            else
            begin
                pend_r_reg <= interp_reg ? mac_sample : cur_r_reg;
            end
        end
        if (load_out)
        begin
            out_l_reg   <= pend_l_reg;
            out_r_reg   <= pend_r_reg;
            out_run_reg <= !emit_more;
            out_se_reg  <= pend_se_reg || (fin_reg && !emit_more);
        end
    end

`ifndef ASSERT_OFF
    a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !pend_reg)
        else $error("Input ready while a result is still pending.");

    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RES_CNT_BITS'(MAX_RESULTS))
        else $error("Result count for one frame exceeds the cap.");

    a_form_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FORM |=> pend_reg && state_reg == ST_EVAL)
        else $error("A formed result was not held for transfer.");

    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> can_load)
        else $error("Output register overwritten before its transfer.");
`endif

endmodule
